[rtl/bdasc_pkg.sv]
// ----------------------------------------------------------------------------
// bdasc_pkg
// Shared constants, command and status types for the binary to decimal text
// converter.
// ----------------------------------------------------------------------------
package bdasc_pkg;

  localparam int VALUE_WIDTH_DEF = 32;

  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_MINUS = 8'h2D;

  localparam logic [3:0] DABBLE_LIMIT = 4'd5;
  localparam logic [3:0] DABBLE_ADD   = 4'd3;

  // decimal digits needed for 2^w - 1 (log10(2) ~ 0.30103)
  function automatic int num_digits(input int w);
    return (w * 30103) / 100000 + 1;
  endfunction

  typedef struct packed {
    logic load;
    logic dabble;
    logic skip;
    logic emit_sign;
    logic emit_digit;
  } cmd_t;

  typedef struct packed {
    logic bits_done;
    logic top_zero;
    logic digit_one;
    logic neg;
    logic out_free;
  } sts_t;

endpackage

[rtl/bdasc_ctrl.sv]
// ----------------------------------------------------------------------------
// bdasc_ctrl
// Sequencer: load, shift-and-add-3 conversion, leading zero skip, then one
// character per output word.
// ----------------------------------------------------------------------------
module bdasc_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  bdasc_pkg::sts_t sts_i,
  output bdasc_pkg::cmd_t cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CONV  = 5'b00010,
    ST_SKIP  = 5'b00100,
    ST_SIGN  = 5'b01000,
    ST_DIGIT = 5'b10000
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd_o.dabble = 1'b1;
        if (sts_i.bits_done) begin
          state_d = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (sts_i.top_zero && !sts_i.digit_one) begin
          cmd_o.skip = 1'b1;
        end else if (sts_i.neg) begin
          state_d = ST_SIGN;
        end else begin
          state_d = ST_DIGIT;
        end
      end
      ST_SIGN: begin
        if (sts_i.out_free) begin
          cmd_o.emit_sign = 1'b1;
          state_d         = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_digit = 1'b1;
          if (sts_i.digit_one) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[rtl/bdasc_datapath.sv]
// ----------------------------------------------------------------------------
// bdasc_datapath
// Magnitude, shift-and-add-3 BCD register, digit counters and the output
// word register.
// ----------------------------------------------------------------------------
module bdasc_datapath #(
  parameter int VALUE_WIDTH = bdasc_pkg::VALUE_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [VALUE_WIDTH-1:0] value_i,
  input  logic                   signed_mode_i,
  input  bdasc_pkg::cmd_t        cmd_i,
  output bdasc_pkg::sts_t        sts_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [7:0]             character_o,
  output logic                   last_o
);

  localparam int ND  = bdasc_pkg::num_digits(VALUE_WIDTH);
  localparam int BW  = ND * 4;
  localparam int BCW = $clog2(VALUE_WIDTH + 1);
  localparam int DCW = $clog2(ND + 1);

  logic [VALUE_WIDTH-1:0] bin_q, bin_d;
  logic [BW-1:0]          bcd_q, bcd_d, bcd_adj;
  logic                   neg_q, neg_d;
  logic [BCW-1:0]         bitcnt_q, bitcnt_d;
  logic [DCW-1:0]         digcnt_q, digcnt_d;
  logic                   valid_q;
  logic [7:0]             char_q;
  logic                   last_q;
  logic                   in_neg;
  logic [3:0]             top_digit;

  assign in_neg    = signed_mode_i & value_i[VALUE_WIDTH-1];
  assign top_digit = bcd_q[BW-1 -: 4];

  always_comb begin
    for (int i = 0; i < ND; i++) begin
      if (bcd_q[i*4 +: 4] >= bdasc_pkg::DABBLE_LIMIT) begin
        bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4] + bdasc_pkg::DABBLE_ADD;
      end else begin
        bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4];
      end
    end
  end

  always_comb begin
    bin_d    = bin_q;
    bcd_d    = bcd_q;
    neg_d    = neg_q;
    bitcnt_d = bitcnt_q;
    digcnt_d = digcnt_q;
    if (cmd_i.load) begin
      bin_d    = in_neg ? (~value_i + VALUE_WIDTH'(1)) : value_i;
      bcd_d    = '0;
      neg_d    = in_neg;
      bitcnt_d = BCW'(VALUE_WIDTH);
      digcnt_d = DCW'(ND);
    end else if (cmd_i.dabble) begin
      bin_d    = {bin_q[VALUE_WIDTH-2:0], 1'b0};
      bcd_d    = {bcd_adj[BW-2:0], bin_q[VALUE_WIDTH-1]};
      bitcnt_d = bitcnt_q - BCW'(1);
    end else if (cmd_i.skip || cmd_i.emit_digit) begin
      bcd_d    = {bcd_q[BW-5:0], 4'd0};
      digcnt_d = digcnt_q - DCW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q    <= bin_d;
    bcd_q    <= bcd_d;
    neg_q    <= neg_d;
    bitcnt_q <= bitcnt_d;
    digcnt_q <= digcnt_d;
  end

  // output word register: hold while stalled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (cmd_i.emit_sign || cmd_i.emit_digit) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_sign) begin
      char_q <= bdasc_pkg::ASCII_MINUS;
      last_q <= 1'b0;
    end else if (cmd_i.emit_digit) begin
      char_q <= bdasc_pkg::ASCII_ZERO + {4'd0, top_digit};
      last_q <= (digcnt_q == DCW'(1));
    end
  end

  assign sts_o.bits_done = (bitcnt_q == BCW'(1));
  assign sts_o.top_zero  = (top_digit == 4'd0);
  assign sts_o.digit_one = (digcnt_q == DCW'(1));
  assign sts_o.neg       = neg_q;
  assign sts_o.out_free  = !valid_q || !out_stall_i;

  assign out_valid_o = valid_q;
  assign character_o = char_q;
  assign last_o      = last_q;

endmodule

[rtl/binary_to_decimal_ascii.sv]
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii
// Converts a binary word to its decimal ASCII text, most significant digit
// first, with a leading '-' for negative signed input and last on the final
// character.
// ----------------------------------------------------------------------------
// One word is converted at a time. The accepting cycle loads the magnitude,
// then the shift-and-add-3 BCD register takes one input bit per cycle, leading
// zero digits are dropped, the sign is decided, an optional '-' is issued, and
// then the digits follow, one per cycle while the output is not stalled.
// Dropped zeros and digits together number num_digits(VALUE_WIDTH). The input
// is taken again once the last character sits in the output register.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii #(
  parameter int VALUE_WIDTH = bdasc_pkg::VALUE_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [VALUE_WIDTH-1:0] value_i,
  input  logic                   signed_mode_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [7:0]             character_o,
  output logic                   last_o
);

  bdasc_pkg::cmd_t cmd;
  bdasc_pkg::sts_t sts;

  bdasc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bdasc_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .value_i       (value_i),
    .signed_mode_i (signed_mode_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .character_o   (character_o),
    .last_o        (last_o)
  );

`ifndef SYNTHESIS
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit_sign || cmd.emit_digit) |-> sts.out_free)
    else $error("character issued while output word still held");

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load, cmd.dabble, cmd.skip, cmd.emit_sign, cmd.emit_digit}))
    else $error("more than one datapath command");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled during conversion");

  a_minus_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && character_o == bdasc_pkg::ASCII_MINUS) |-> !last_o)
    else $error("sign marked as last character");
`endif

endmodule

[bench/tb_binary_to_decimal_ascii.sv]
// ----------------------------------------------------------------------------
// tb_binary_to_decimal_ascii
// Drives 32-bit words, signed and unsigned, into the converter and checks
// every ASCII character and its last flag against a predicted text. Runs a
// directed set of boundary values, random words under three idling mixes,
// and a long output hold-off that backs the block up into its input.
// ----------------------------------------------------------------------------
module tb_binary_to_decimal_ascii;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VW         = bdasc_pkg::VALUE_WIDTH_DEF;
  localparam int CYCLE_MAX  = 1000000;
  localparam int HOLD_LONG  = 400;
  localparam int TAIL_WAIT  = 100;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } text_char_t;

  logic          clk_i         = 1'b0;
  logic          rst_ni        = 1'b0;
  logic          in_valid_i    = 1'b0;
  logic          in_stall_o;
  logic [VW-1:0] value_i       = '0;
  logic          signed_mode_i = 1'b0;
  logic          out_valid_o;
  logic          out_stall_i   = 1'b0;
  logic [7:0]    character_o;
  logic          last_o;

  text_char_t    expected_text[$];
  int            mismatches    = 0;
  int            cycle_count   = 0;
  int            tx_idle_pct   = 0;
  int            rx_idle_pct   = 0;
  logic          rx_hold       = 1'b0;

  binary_to_decimal_ascii #(
    .VALUE_WIDTH(VW)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .value_i      (value_i),
    .signed_mode_i(signed_mode_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .character_o  (character_o),
    .last_o       (last_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_MAX) begin
      $display("tb_binary_to_decimal_ascii: errors");
      $finish;
    end
  end

  function automatic void predict_text(input logic [VW-1:0] word, input logic signed_mode);
    logic [VW-1:0] mag;
    logic          neg;
    logic [3:0]    digits[$];
    text_char_t    tc;
    neg = signed_mode && word[VW-1];
    mag = neg ? (~word + 1'b1) : word;
    do begin
      digits.push_front(4'(mag % 10));
      mag = mag / 10;
    end while (mag != '0);
    if (neg) begin
      tc.character = bdasc_pkg::ASCII_MINUS;
      tc.last      = 1'b0;
      expected_text.push_back(tc);
    end
    foreach (digits[i]) begin
      tc.character = bdasc_pkg::ASCII_ZERO + 8'(digits[i]);
      tc.last      = (i == digits.size() - 1);
      expected_text.push_back(tc);
    end
  endfunction

  // drive one word and hold it until taken
  task automatic send_word(input logic [VW-1:0] word, input logic signed_mode);
    int gap;
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      gap = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 90 : 6);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    value_i       <= word;
    signed_mode_i <= signed_mode;
    do @(posedge clk_i); while (in_stall_o);
    predict_text(word, signed_mode);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_text.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= rx_hold || ($urandom_range(0, 99) < rx_idle_pct);
  end

  always @(posedge clk_i) begin
    text_char_t exp_c;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_text.size() == 0) begin
        $error("unexpected character: character=%h last=%b", character_o, last_o);
        mismatches++;
      end else begin
        exp_c = expected_text.pop_front();
        if (character_o !== exp_c.character) begin
          $error("character: expected %h, actual %h", exp_c.character, character_o);
          mismatches++;
        end
        if (last_o !== exp_c.last) begin
          $error("last: expected %b, actual %b", exp_c.last, last_o);
          mismatches++;
        end
      end
    end
  end

  task automatic test_boundaries();
    send_word(32'd0, 1'b0);
    send_word(32'd0, 1'b1);
    send_word(32'd1, 1'b0);
    send_word(32'd9, 1'b1);
    send_word(32'd10, 1'b0);
    send_word(32'd99, 1'b0);
    send_word(32'd100, 1'b1);
    send_word(32'd999999999, 1'b0);
    send_word(32'd1000000000, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b1);
    send_word(32'h8000_0000, 1'b1);
    send_word(32'h8000_0000, 1'b0);
    send_word(32'h7FFF_FFFF, 1'b1);
    send_word(32'h7FFF_FFFF, 1'b0);
    send_word(32'hFFFF_FFF6, 1'b1);
    send_word(32'hFFFF_FFF7, 1'b1);
    send_word(32'hC465_3600, 1'b1);
    send_word(32'h5555_5555, 1'b0);
    send_word(32'hAAAA_AAAA, 1'b1);
    wait_drained();
  endtask

  task automatic test_random_words(input int count, input int tx_pct, input int rx_pct);
    logic [VW-1:0] word;
    logic          sgn;
    tx_idle_pct = tx_pct;
    rx_idle_pct <= rx_pct;
    repeat (count) begin
      word = $urandom();
      sgn  = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 3) != 0) begin
        word = word >> $urandom_range(0, VW - 1);
        if (sgn && $urandom_range(0, 1)) word = ~word + 1'b1;
      end
      send_word(word, sgn);
    end
    wait_drained();
  endtask

  task automatic test_output_hold();
    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    fork
      begin
        rx_hold <= 1'b1;
        repeat (HOLD_LONG) @(posedge clk_i);
        rx_hold <= 1'b0;
      end
    join_none
    repeat (10) send_word($urandom(), 1'b1);
    wait_drained();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_boundaries();
    test_output_hold();
    test_random_words(150, 21, 57);
    test_random_words(150, 57, 21);
    test_random_words(140, 0, 0);
    repeat (TAIL_WAIT) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_binary_to_decimal_ascii: clean");
    end else begin
      $display("tb_binary_to_decimal_ascii: errors");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/bdasc_pkg.sv
rtl/bdasc_ctrl.sv
rtl/bdasc_datapath.sv
rtl/binary_to_decimal_ascii.sv
bench/tb_binary_to_decimal_ascii.sv
